>>> design/strmq_pkg.sv
// Package for the sparse-table range-maximum engine.
// Holds table geometry, field widths, item codes, the table entry type and helpers.
// No dependencies; the channel interfaces and the top level use it.
`default_nettype none

package strmq_pkg;

  // Table geometry.
  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVEL_COUNT  = 11;
  localparam int TABLE_DEPTH  = LEVEL_COUNT * MAX_ELEMENTS;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int LVL_W        = $clog2(LEVEL_COUNT);

  // Field widths.
  localparam int MODE_W = 2;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Item codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // One table entry: a value and the element index it came from.
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    idx_t                    idx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Larger of two entries; on equal values the larger index wins.
  function automatic entry_t entry_max(entry_t a, entry_t b);
    logic b_wins;
    b_wins = (b.val > a.val) || ((b.val == a.val) && (b.idx > a.idx));
    return b_wins ? b : a;
  endfunction

  // Flat memory address of entry idx in level lvl.
  function automatic addr_t tbl_addr(lvl_t lvl, idx_t idx);
    logic [31:0] flat;
    flat = 32'(lvl) * 32'(MAX_ELEMENTS) + 32'(idx);
    return flat[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/strmq_if.sv
// Channel interfaces of the sparse-table range-maximum engine.
// Input items, result items and the element-count write channel.
// Depends on strmq_pkg for field widths.
`default_nettype none

// Input item channel.
interface strmq_in_if;
  logic                              valid;
  logic                              ready;
  logic [strmq_pkg::MODE_W-1:0]      mode;
  logic signed [strmq_pkg::VAL_W-1:0] element_value;
  logic [strmq_pkg::IDX_W-1:0]       position;
  logic [strmq_pkg::IDX_W-1:0]       left_index;
  logic [strmq_pkg::IDX_W-1:0]       right_index;

  modport source (output valid, mode, element_value, position, left_index, right_index,
                  input ready);
  modport sink (input valid, mode, element_value, position, left_index, right_index,
                output ready);
endinterface

// Result item channel.
interface strmq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [strmq_pkg::VAL_W-1:0] max_value;
  logic [strmq_pkg::IDX_W-1:0]        max_position;
  logic                               range_error;

  modport source (output valid, max_value, max_position, range_error, input ready);
  modport sink (input valid, max_value, max_position, range_error, output ready);
endinterface

// Element-count write channel.
interface strmq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [strmq_pkg::CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> design/strmq_ram.sv
// Generic synchronous RAM: one write port, two read ports with registered data.
// Both read data registers hold while the shared read enable is low.
// No package dependency.
`default_nettype none

module strmq_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

>>> design/sparse_table_range_max.sv
// Top level of the sparse-table range-maximum engine.
// Depends on strmq_pkg, the channel interfaces in strmq_if and the table RAM strmq_ram.
//
//   channel   dir  payload                                           handshake
//   in_ch     in   mode, element_value, position, left/right_index    valid/ready
//   out_ch    out  max_value, max_position, range_error               valid/ready
//   cfg_ch    in   data (element_count)                                valid/ready
//
// A load is one table write. A query reads its two window entries together from
// the dual-read table RAM, then compares them into the output register. A build
// walks levels 1 to LEVEL_COUNT-1 over the n elements in use: one entry per
// cycle through the RAM, with a gap state after each level.
// Reset is synchronous; the table contents are undefined until written and get
// no clearing pass. A query waits in its compare cycle while the output
// register is still held by a stalled consumer; loads and builds do not wait.
`default_nettype none

module sparse_table_range_max (
  input  wire logic clk,
  input  wire logic rst_n,
  strmq_in_if.sink    in_ch,
  strmq_out_if.source out_ch,
  strmq_cfg_if.sink   cfg_ch
);

  import strmq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_QUERY = 4'b0010,
    ST_BUILD = 4'b0100,
    ST_GAP   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  lvl_t   lvl_r, lvl_nxt;
  idx_t   j_r, j_nxt;
  cnt_t   count_r;
  logic   wr_pend_r, wr_pend_nxt;
  addr_t  wr_addr_r, wr_addr_nxt;
  logic   qerr_r, qerr_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  idx_t                    out_pos_r, out_pos_nxt;
  logic                    out_err_r, out_err_nxt;

  // RAM port signals.
  logic   ram_we, ram_re;
  addr_t  ram_waddr, ram_raddr_a, ram_raddr_b;
  entry_t ram_wdata, rd_a, rd_b, best;

  logic        in_accept;
  cnt_t        n_used;
  cnt_t        q_len;
  lvl_t        q_lg;
  idx_t        q_right_start;
  logic        q_err;
  logic [31:0] k_sum, n_last;
  idx_t        k_idx;
  entry_t      load_entry;

  strmq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign best = entry_max(rd_a, rd_b);

  // Element count register; always ready to take a write.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      count_r <= cfg_ch.data;
    end
  end

  // Count in use, limited to the table size.
  always_comb begin
    if (32'(count_r) > 32'(MAX_ELEMENTS)) begin
      n_used = CNT_W'(MAX_ELEMENTS);
    end else begin
      n_used = count_r;
    end
  end

  // Query window: the level is floor(log2(length)), capped at the top level.
  always_comb begin
    int lg_raw;
    lg_raw = 0;
    q_len  = {1'b0, in_ch.right_index} - {1'b0, in_ch.left_index} + CNT_W'(1);
    for (int i = 0; i < CNT_W; i++) begin
      if (q_len[i]) begin
        lg_raw = i;
      end
    end
    if (lg_raw > LEVEL_COUNT - 1) begin
      lg_raw = LEVEL_COUNT - 1;
    end
    q_lg          = LVL_W'(lg_raw);
    q_right_start = IDX_W'({1'b0, in_ch.right_index} - (CNT_W'(1) << q_lg) + CNT_W'(1));
    q_err         = (in_ch.left_index > in_ch.right_index) ||
                    ({1'b0, in_ch.right_index} >= n_used);
  end

  // Second build operand, clamped to the last element in use.
  always_comb begin
    k_sum  = 32'(j_r) + (32'd1 << (lvl_r - LVL_W'(1)));
    n_last = 32'(n_used) - 32'd1;
    if (k_sum > n_last) begin
      k_idx = n_last[IDX_W-1:0];
    end else begin
      k_idx = k_sum[IDX_W-1:0];
    end
  end

  assign load_entry.val = in_ch.element_value;
  assign load_entry.idx = in_ch.position;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Sequencer and table access.
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    j_nxt         = j_r;
    wr_pend_nxt   = wr_pend_r;
    wr_addr_nxt   = wr_addr_r;
    qerr_nxt      = qerr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_addr_r;
    ram_wdata     = best;
    ram_re        = 1'b0;
    ram_raddr_a   = tbl_addr(q_lg, in_ch.left_index);
    ram_raddr_b   = tbl_addr(q_lg, q_right_start);

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (mode_t'(in_ch.mode))
            MODE_LOAD: begin
              if (32'(in_ch.position) < 32'(MAX_ELEMENTS)) begin
                ram_we    = 1'b1;
                ram_waddr = tbl_addr(LVL_W'(0), in_ch.position);
                ram_wdata = load_entry;
              end
            end
            MODE_BUILD: begin
              if (n_used != '0) begin
                state_nxt = ST_BUILD;
                lvl_nxt   = LVL_W'(1);
                j_nxt     = '0;
              end
            end
            MODE_QUERY: begin
              ram_re    = 1'b1;
              qerr_nxt  = q_err;
              state_nxt = ST_QUERY;
            end
            default: begin
            end
          endcase
        end
      end
      ST_QUERY: begin
        // Read data holds until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = qerr_r;
          out_value_nxt = qerr_r ? '0 : best.val;
          out_pos_nxt   = qerr_r ? '0 : best.idx;
          state_nxt     = ST_IDLE;
        end
      end
      ST_BUILD: begin
        // Read both operands from the level below; write the result next cycle.
        ram_re      = 1'b1;
        ram_raddr_a = tbl_addr(lvl_r - LVL_W'(1), j_r);
        ram_raddr_b = tbl_addr(lvl_r - LVL_W'(1), k_idx);
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = tbl_addr(lvl_r, j_r);
        if ({1'b0, j_r} == n_used - CNT_W'(1)) begin
          state_nxt = ST_GAP;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_GAP: begin
        // The level's last write lands here, before the next level reads it.
        wr_pend_nxt = 1'b0;
        if (lvl_r == LVL_W'(LEVEL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          lvl_nxt   = lvl_r + LVL_W'(1);
          j_nxt     = '0;
          state_nxt = ST_BUILD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Pending build write-back.
    if (wr_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_r;
      ram_wdata = best;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and counter registers.
  always_ff @(posedge clk) begin
    lvl_r       <= lvl_nxt;
    j_r         <= j_nxt;
    wr_addr_r   <= wr_addr_nxt;
    qerr_r      <= qerr_nxt;
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_err_r   <= out_err_nxt;
  end

  // Result channel.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.max_value    = out_value_r;
  assign out_ch.max_position = out_pos_r;
  assign out_ch.range_error  = out_err_r;

endmodule

`default_nettype wire

>>> tb/sv/sparse_table_range_max_test.sv
`timescale 1ns / 1ps
// Testbench for sparse_table_range_max: element loads, table builds and range-maximum
// queries, checked field by field against a sparse table kept inside the bench.
// Depends on strmq_pkg and the channel interfaces in strmq_if.

module sparse_table_range_max_test;
  import strmq_pkg::*;

  // Cycles with no accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 60000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    idx_t                    pos;
    logic                    err;
  } rmq_result_t;

  logic clk = 1'b0;
  logic rst_n;

  strmq_in_if  in_bus ();
  strmq_out_if out_bus ();
  strmq_cfg_if cfg_bus ();

  sparse_table_range_max dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the sparse table, with a flag per entry that marks it written.
  entry_t      level_mem [LEVEL_COUNT][MAX_ELEMENTS];
  bit          level_set [LEVEL_COUNT][MAX_ELEMENTS];
  cnt_t        elem_count;
  rmq_result_t pending_max [$];

  int  errors = 0;
  int  results_checked = 0;
  int  range_errors_seen = 0;
  int  loads_sent = 0;
  int  builds_sent = 0;
  int  counts_written = 0;
  int  stall_cycles = 0;
  int  hold_request = 0;
  bit  gaps_on = 1'b1;

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // Counts above the table size behave as a full table.
  function automatic int active_count();
    return (elem_count > cnt_t'(MAX_ELEMENTS)) ? MAX_ELEMENTS : int'(elem_count);
  endfunction

  // True when a ranks above b: signed value first, then the larger index.
  function automatic bit outranks(entry_t a, entry_t b);
    if ($signed(a.val) != $signed(b.val)) return $signed(a.val) > $signed(b.val);
    return a.idx > b.idx;
  endfunction

  // Level whose windows cover a range of len elements with two overlapping reads.
  function automatic int window_level(int len);
    int lg;
    lg = 0;
    while ((len >> (lg + 1)) != 0) lg++;
    if (lg > LEVEL_COUNT - 1) lg = LEVEL_COUNT - 1;
    return lg;
  endfunction

  function automatic bit range_bad(int l, int r);
    return (l > r) || (r >= active_count());
  endfunction

  // A query may only touch entries that have been written since reset.
  function automatic bit query_readable(int l, int r);
    int lg;
    if (range_bad(l, r)) return 1'b1;
    lg = window_level(r - l + 1);
    return level_set[lg][l] && level_set[lg][r - (1 << lg) + 1];
  endfunction

  function automatic bit build_readable();
    for (int j = 0; j < active_count(); j++)
      if (!level_set[0][j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void rebuild_levels();
    int n;
    int k;
    n = active_count();
    for (int lvl = 1; lvl < LEVEL_COUNT; lvl++) begin
      for (int j = 0; j < n; j++) begin
        k = j + (1 << (lvl - 1));
        if (k > n - 1) k = n - 1;
        level_mem[lvl][j] = outranks(level_mem[lvl-1][k], level_mem[lvl-1][j]) ?
                            level_mem[lvl-1][k] : level_mem[lvl-1][j];
        level_set[lvl][j] = 1'b1;
      end
    end
  endfunction

  function automatic rmq_result_t predict_max(int l, int r);
    rmq_result_t res;
    entry_t      lo_win;
    entry_t      hi_win;
    int          lg;
    res.value = '0;
    res.pos   = '0;
    res.err   = 1'b1;
    if (range_bad(l, r)) return res;
    lg = window_level(r - l + 1);
    lo_win = level_mem[lg][l];
    hi_win = level_mem[lg][r - (1 << lg) + 1];
    if (outranks(hi_win, lo_win)) lo_win = hi_win;
    res.value = lo_win.val;
    res.pos   = lo_win.idx;
    res.err   = 1'b0;
    return res;
  endfunction

  // Extremes and small values are favored so that ties come up often.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one item and updates the shadow table once the transaction completes.
  task automatic send_item(mode_t op, logic [VAL_W-1:0] value, int pos, int l, int r);
    int gap;
    entry_t e;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= op;
    in_bus.element_value <= value;
    in_bus.position      <= idx_t'(pos);
    in_bus.left_index    <= idx_t'(l);
    in_bus.right_index   <= idx_t'(r);
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    case (op)
      MODE_LOAD: begin
        e.val = value;
        e.idx = idx_t'(pos);
        level_mem[0][pos] = e;
        level_set[0][pos] = 1'b1;
        loads_sent++;
      end
      MODE_BUILD: begin
        rebuild_levels();
        builds_sent++;
      end
      MODE_QUERY: pending_max.insert(pending_max.size(), predict_max(l, r));
      default: ;
    endcase
  endtask

  task automatic load_elem(int pos, logic [VAL_W-1:0] value);
    send_item(MODE_LOAD, value, pos, $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  task automatic build_table_cmd();
    if (build_readable())
      send_item(MODE_BUILD, $urandom(), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023));
  endtask

  // Queries that would read never-written entries are dropped.
  task automatic query_range(int l, int r);
    if (query_readable(l, r))
      send_item(MODE_QUERY, $urandom(), $urandom_range(0, 1023), l, r);
  endtask

  task automatic idle_item();
    send_item(MODE_NOP, $urandom(), $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
  endtask

  task automatic load_all(int n);
    for (int p = 0; p < n; p++) load_elem(p, pick_value());
  endtask

  // Well-formed query in [0, n-1], short or long.
  task automatic random_query(int n);
    int l;
    int r;
    l = $urandom_range(0, n - 1);
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(l, n - 1);
    end else begin
      r = l + $urandom_range(0, 15);
      if (r > n - 1) r = n - 1;
    end
    query_range(l, r);
  endtask

  // Drops valid, waits for every pending result, then lets extra cycles pass.
  task automatic settle(int extra);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_max.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // A build may still be walking the table after the last result, so wait it out.
  function automatic int build_cycles();
    return (LEVEL_COUNT - 1) * (active_count() + 1) + 16;
  endfunction

  task automatic write_count(int value);
    settle(build_cycles());
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= cnt_t'(value);
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    elem_count = cnt_t'(value);
    counts_written++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: random stalls per transaction, plus a long hold when one is requested.
  initial begin : result_sink
    int wait_cycles;
    out_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      wait_cycles = gaps_on ? $urandom_range(0, 3) : 0;
      if (hold_request > 0) begin
        wait_cycles  = hold_request;
        hold_request = 0;
      end
      if (wait_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
    end
  end

  task automatic report(string field, longint want, longint got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Compares each result transaction with the oldest pending query.
  always @(posedge clk) begin : result_check
    rmq_result_t want;
    if (rst_n === 1'b1) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;

      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (pending_max.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t ns: result with no pending query, expected none, actual %0d/%0d/%0b",
                     $time, out_bus.max_value, out_bus.max_position, out_bus.range_error);
        end else begin
          want = pending_max.pop_front();
          if (out_bus.max_value !== want.value)
            report("max_value", want.value, $signed(out_bus.max_value));
          if (out_bus.max_position !== want.pos)
            report("max_position", want.pos, out_bus.max_position);
          if (out_bus.range_error !== want.err)
            report("range_error", want.err, out_bus.range_error);
          results_checked++;
          if (want.err) range_errors_seen++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset the count is one; only element 0 is in range.
  task automatic test_reset_state();
    query_range(0, 1);
    query_range(1, 0);
    load_elem(0, 32'h1234_5678);
    query_range(0, 0);
    query_range(1023, 1023);
  endtask

  // Extreme values, ties, a load past the count, bad ranges and a no-op item.
  task automatic test_directed();
    write_count(8);
    load_elem(0, 32'h8000_0000);
    load_elem(1, 32'h7fff_ffff);
    load_elem(2, 32'h0000_0000);
    load_elem(3, 32'hffff_ffff);
    load_elem(4, 32'h7fff_ffff);
    load_elem(5, 32'hffff_ffff);
    load_elem(6, 32'h8000_0000);
    load_elem(7, 32'h0000_0005);
    load_elem(1023, 32'h7fff_ffff);
    build_table_cmd();
    query_range(0, 7);
    query_range(0, 3);
    query_range(2, 3);
    query_range(5, 6);
    query_range(6, 6);
    query_range(3, 7);
    query_range(7, 8);
    query_range(5, 4);
    query_range(0, 1023);
    idle_item();
  endtask

  // A count of zero: build does nothing and every query fails; then a count of one again.
  task automatic test_zero_count();
    write_count(0);
    build_table_cmd();
    query_range(0, 0);
    query_range(0, 1023);
    write_count(1);
    query_range(0, 0);
    query_range(0, 1);
  endtask

  // Long receiver hold while queries keep coming, then a full sender pause.
  task automatic test_backpressure();
    write_count(32);
    load_all(32);
    build_table_cmd();
    hold_request = LONG_HOLD;
    repeat (30) random_query(32);
    settle(0);
    repeat (10) random_query(32);
  endtask

  // Full table, then a count above the table size that must act as a full table.
  task automatic test_full_table();
    write_count(MAX_ELEMENTS);
    load_all(MAX_ELEMENTS);
    build_table_cmd();
    query_range(0, MAX_ELEMENTS - 1);
    query_range(MAX_ELEMENTS - 1, MAX_ELEMENTS - 1);
    query_range(512, MAX_ELEMENTS - 1);
    repeat (50) random_query(MAX_ELEMENTS);
    write_count(2047);
    query_range(0, MAX_ELEMENTS - 1);
    repeat (10) load_elem($urandom_range(0, MAX_ELEMENTS - 1), pick_value());
    repeat (10) random_query(MAX_ELEMENTS);
    build_table_cmd();
    repeat (30) random_query(MAX_ELEMENTS);
  endtask

  // Random sessions: load every element, build, then mostly queries with noise mixed in.
  task automatic test_random_sessions();
    int n;
    int pick;
    for (int phase = 0; phase < 14; phase++) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 48);
      write_count(n);
      gaps_on = (phase % 5 != 2);
      load_all(n);
      build_table_cmd();
      repeat (25) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          random_query(n);
        else if (pick < 70)
          query_range($urandom_range(0, 1023), $urandom_range(0, 1023));
        else if (pick < 85)
          load_elem($urandom_range(0, 1023), pick_value());
        else if (pick < 90)
          build_table_cmd();
        else
          idle_item();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin : run
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.mode          = MODE_NOP;
    in_bus.element_value = '0;
    in_bus.position      = '0;
    in_bus.left_index    = '0;
    in_bus.right_index   = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.data         = '0;
    elem_count           = cnt_t'(1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed();
    test_zero_count();
    test_backpressure();
    test_full_table();
    test_random_sessions();
    settle(build_cycles());

    $display("tb: %0d results checked (%0d with range error) after %0d loads and %0d builds",
             results_checked, range_errors_seen, loads_sent, builds_sent);
    $display("tb: %0d element-count settings, from zero up to past the table size",
             counts_written);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
